### rtl/core/box_frustum_plane_test_unit_assert.svh
// Assertion macros shared by the frustum plane test RTL
`ifndef BOX_FRUSTUM_PLANE_TEST_UNIT_ASSERT_SVH
`define BOX_FRUSTUM_PLANE_TEST_UNIT_ASSERT_SVH

// implication in the same cycle
`define BFPT_ASSERT_IMP(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// implication in the next cycle
`define BFPT_ASSERT_NXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/bfpt_pkg.sv
// Package: types and constants of the box frustum plane test
package bfpt_pkg;

	localparam int NUM_PLANES_DEF = 6;
	localparam int MASK_W         = 6;
	localparam int IDX_W          = 3;
	localparam int NRM_W          = 18;
	localparam int CRD_W          = 32;
	localparam int EXT_W          = 31;
	localparam int IN_DATA_W      = 280;
	localparam int OUT_DATA_W     = 8;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TEST = 1'b1
	} bfpt_op_t;

	// transaction travelling along the plane cells
	typedef struct packed {
		bfpt_op_t                  op;
		logic [IDX_W-1:0]          idx;
		logic signed [NRM_W-1:0]   nx;
		logic signed [NRM_W-1:0]   ny;
		logic signed [NRM_W-1:0]   nz;
		logic signed [CRD_W-1:0]   ofs;
		logic signed [CRD_W-1:0]   cx;
		logic signed [CRD_W-1:0]   cy;
		logic signed [CRD_W-1:0]   cz;
		logic [EXT_W-1:0]          ex;
		logic [EXT_W-1:0]          ey;
		logic [EXT_W-1:0]          ez;
		logic                      outside;
		logic [MASK_W-1:0]         mask;
	} bfpt_tok_t;

endpackage

### rtl/core/bfpt_cell.sv
// Plane cell: holds one clipping plane and tests each passing box against it
module bfpt_cell #(
	parameter int CELL_IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bfpt_pkg::bfpt_tok_t in_tok,
	output logic                out_valid,
	input  logic                out_ready,
	output bfpt_pkg::bfpt_tok_t out_tok
);
	import bfpt_pkg::*;

	`include "box_frustum_plane_test_unit_assert.svh"

	localparam int PRD_W  = NRM_W + CRD_W;
	localparam int RPRD_W = NRM_W + EXT_W;
	localparam int SUM_W  = PRD_W + 2;
	localparam int CMP_W  = SUM_W + 1;

	logic signed [NRM_W-1:0] nx_q, ny_q, nz_q;
	logic signed [CRD_W-1:0] ofs_q;

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;
	logic wr_plane;

	bfpt_tok_t tok_s1, tok_s2, tok_s3, tok_upd;

	logic [NRM_W-1:0] ax, ay, az;
	logic signed [PRD_W-1:0] px_s1, py_s1, pz_s1;
	logic [RPRD_W-1:0] rx_s1, ry_s1, rz_s1;
	logic signed [CRD_W-1:0] d_s1;
	logic signed [SUM_W-1:0] dist_s2;
	logic [SUM_W-2:0] rad_s2;
	logic signed [CMP_W-1:0] d_plus_r, r_minus_d;
	logic [MASK_W-1:0] span_bit;

	assign en3      = !v_s3 || out_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	assign wr_plane = in_valid && en1 && (in_tok.op == OP_LOAD)
	                  && (in_tok.idx == IDX_W'(CELL_IDX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nx_q  <= '0;
			ny_q  <= '0;
			nz_q  <= '0;
			ofs_q <= '0;
		end else if (wr_plane) begin
			nx_q  <= in_tok.nx;
			ny_q  <= in_tok.ny;
			nz_q  <= in_tok.nz;
			ofs_q <= in_tok.ofs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// magnitudes of the normal, 2^17 fits unsigned
	assign ax = nx_q[NRM_W-1] ? NRM_W'(-nx_q) : NRM_W'(nx_q);
	assign ay = ny_q[NRM_W-1] ? NRM_W'(-ny_q) : NRM_W'(ny_q);
	assign az = nz_q[NRM_W-1] ? NRM_W'(-nz_q) : NRM_W'(nz_q);

	always_ff @(posedge clk) begin
		if (en1) begin
			tok_s1 <= in_tok;
			px_s1  <= PRD_W'(nx_q) * PRD_W'(in_tok.cx);
			py_s1  <= PRD_W'(ny_q) * PRD_W'(in_tok.cy);
			pz_s1  <= PRD_W'(nz_q) * PRD_W'(in_tok.cz);
			rx_s1  <= RPRD_W'(ax) * RPRD_W'(in_tok.ex);
			ry_s1  <= RPRD_W'(ay) * RPRD_W'(in_tok.ey);
			rz_s1  <= RPRD_W'(az) * RPRD_W'(in_tok.ez);
			d_s1   <= ofs_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			tok_s2  <= tok_s1;
			dist_s2 <= SUM_W'(px_s1) + SUM_W'(py_s1) + SUM_W'(pz_s1)
			           + SUM_W'($signed({d_s1, 16'h0000}));
			rad_s2  <= (SUM_W-1)'(rx_s1) + (SUM_W-1)'(ry_s1) + (SUM_W-1)'(rz_s1);
		end
	end

	assign d_plus_r  = CMP_W'(dist_s2) + $signed({2'b00, rad_s2});
	assign r_minus_d = $signed({2'b00, rad_s2}) - CMP_W'(dist_s2);

	generate
		if (CELL_IDX < MASK_W) begin : g_bit
			assign span_bit = MASK_W'(1) << CELL_IDX;
		end else begin : g_nobit
			assign span_bit = '0;
		end
	endgenerate

	always_comb begin
		tok_upd         = tok_s2;
		tok_upd.outside = tok_s2.outside | d_plus_r[CMP_W-1];
		tok_upd.mask    = r_minus_d[CMP_W-1] ? tok_s2.mask : (tok_s2.mask | span_bit);
	end

	always_ff @(posedge clk) begin
		if (en3) tok_s3 <= tok_upd;
	end

	assign out_valid = v_s3;
	assign out_tok   = tok_s3;

	`BFPT_ASSERT_NXT(a_plane_wr, wr_plane, ofs_q == $past(in_tok.ofs), "plane load not stored")
	`BFPT_ASSERT_NXT(a_out_sticky, en3 && v_s2 && tok_s2.outside, tok_s3.outside,
		"outside flag lost in cell")
	`BFPT_ASSERT_NXT(a_out_hold, v_s3 && !out_ready, v_s3 && $stable(tok_s3),
		"stalled cell output changed")

endmodule

### rtl/core/box_frustum_plane_test_unit.sv
// Top level: box against clipping planes test, a chain of plane cells
//
//  channel  | dir | tdata (low bit up)                          | tuser
//  s_axis   | in  | plane_index, normal_x/y/z, plane_offset,     | opcode
//           |     | center_x/y/z, half_size_x/y/z, 2 zero bits   |
//  m_axis   | out | box_outside, crossed_planes, 1 zero bit      | -
//
// One transaction accepted per cycle unless back-pressure stalls the chain; box results are registered at the output.
// Each plane cell has three stages: products, sums, compare.
// Plane loads travel the chain and write their plane in order; they give no result.
// Planes reset to zero. Stalls collapse bubbles stage by stage.
module box_frustum_plane_test_unit #(
	parameter int NUM_PLANES = bfpt_pkg::NUM_PLANES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// plane_index, normal_x, normal_y, normal_z, plane_offset, center_x, center_y,
	// center_z, half_size_x, half_size_y, half_size_z, zero fill
	input  logic [bfpt_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// opcode
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// box_outside, crossed_planes, zero fill
	output logic [bfpt_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
	import bfpt_pkg::*;

	`include "box_frustum_plane_test_unit_assert.svh"

	bfpt_tok_t chain_tok [NUM_PLANES+1];
	logic [NUM_PLANES:0] chain_vld, chain_rdy;

	logic m_tvalid_q;
	logic out_take;
	logic last_test;
	logic outside_q;
	logic [MASK_W-1:0] mask_q;

	always_comb begin
		chain_tok[0].op      = bfpt_op_t'(s_axis_tuser);
		chain_tok[0].idx     = s_axis_tdata[2:0];
		chain_tok[0].nx      = s_axis_tdata[20:3];
		chain_tok[0].ny      = s_axis_tdata[38:21];
		chain_tok[0].nz      = s_axis_tdata[56:39];
		chain_tok[0].ofs     = s_axis_tdata[88:57];
		chain_tok[0].cx      = s_axis_tdata[120:89];
		chain_tok[0].cy      = s_axis_tdata[152:121];
		chain_tok[0].cz      = s_axis_tdata[184:153];
		chain_tok[0].ex      = s_axis_tdata[215:185];
		chain_tok[0].ey      = s_axis_tdata[246:216];
		chain_tok[0].ez      = s_axis_tdata[277:247];
		chain_tok[0].outside = 1'b0;
		chain_tok[0].mask    = '0;
	end

	assign chain_vld[0]  = s_axis_tvalid;
	assign s_axis_tready = chain_rdy[0];

	genvar gi;
	generate
		for (gi = 0; gi < NUM_PLANES; gi++) begin : g_cell
			bfpt_cell #(
				.CELL_IDX (gi)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.in_valid  (chain_vld[gi]),
				.in_ready  (chain_rdy[gi]),
				.in_tok    (chain_tok[gi]),
				.out_valid (chain_vld[gi+1]),
				.out_ready (chain_rdy[gi+1]),
				.out_tok   (chain_tok[gi+1])
			);
		end
	endgenerate

	// loads leave the chain here
	assign last_test             = chain_tok[NUM_PLANES].op == OP_TEST;
	assign out_take              = !m_tvalid_q || m_axis_tready;
	assign chain_rdy[NUM_PLANES] = !last_test || out_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_take) begin
			m_tvalid_q <= chain_vld[NUM_PLANES] && last_test;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take && chain_vld[NUM_PLANES] && last_test) begin
			outside_q <= chain_tok[NUM_PLANES].outside;
			mask_q    <= chain_tok[NUM_PLANES].outside ? '0 : chain_tok[NUM_PLANES].mask;
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = {1'b0, mask_q, outside_q};

	`BFPT_ASSERT_IMP(a_outside_mask, m_tvalid_q && outside_q, mask_q == '0,
		"outside box reports crossed planes")

endmodule
